// ===== design/dtq_pkg.sv =====
// Shared types and constants for the deadline timer queue.
// Holds the stored entry layout, result and state encodings.
// No dependencies; every other design file refers to it by scoped names.
package dtq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int MAX_RESULTS      = 16;
    localparam int EMIT_W           = $clog2(MAX_RESULTS);
    localparam int DL_W             = 32;
    localparam int ID_W             = 8;
    localparam int ORDER_W          = 32;

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_EXPIRED  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic [DL_W-1:0]    deadline;
        logic [ID_W-1:0]    task_id;
        logic [ORDER_W-1:0] order;
    } entry_t;

    typedef struct packed {
        kind_t           kind;
        logic [ID_W-1:0] task_id;
        logic [DL_W-1:0] deadline;
        logic            last;
    } result_t;

    typedef struct packed {
        logic clear;
        logic load;
    } scan_ctl_t;

endpackage

// ===== design/dtq_entry_mem.sv =====
// Entry store of the deadline timer queue: one write port, one read port.
// Read data is registered, so it appears in the cycle after the address.
// Depends on dtq_pkg for the entry layout.
module dtq_entry_mem #(
    parameter int DEPTH = dtq_pkg::DEFAULT_CAPACITY
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  dtq_pkg::entry_t          wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output dtq_pkg::entry_t          rd_data
);

    dtq_pkg::entry_t mem [DEPTH];
    dtq_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/dtq_min_finder.sv =====
// Scan accumulator: takes one stored entry per beat and keeps the earliest due one.
// Due entries are counted; ties on deadline go to the oldest serial.
// Depends on dtq_pkg.
module dtq_min_finder #(
    parameter int CAPACITY = dtq_pkg::DEFAULT_CAPACITY
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dtq_pkg::scan_ctl_t              ctl,
    input  dtq_pkg::entry_t                 rd_entry,
    input  logic [$clog2(CAPACITY)-1:0]     rd_idx,
    input  logic [dtq_pkg::DL_W-1:0]        now_ticks,
    input  logic [dtq_pkg::ORDER_W-1:0]     serial,
    output logic                            found,
    output dtq_pkg::entry_t                 best,
    output logic [$clog2(CAPACITY)-1:0]     best_idx,
    output logic [$clog2(CAPACITY+1)-1:0]   due_cnt
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                        found_reg;
    dtq_pkg::entry_t             best_reg;
    logic [IW-1:0]               best_idx_reg;
    logic [dtq_pkg::ORDER_W-1:0] best_age_reg;
    logic [CW-1:0]               due_cnt_reg;
    logic [dtq_pkg::ORDER_W-1:0] in_age;
    logic                        is_due;
    logic                        better;

    always_comb begin
        in_age = rd_entry.order - serial;
        is_due = rd_entry.deadline <= now_ticks;
        better = !found_reg || (rd_entry.deadline < best_reg.deadline) ||
                 ((rd_entry.deadline == best_reg.deadline) && (in_age < best_age_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg   <= 1'b0;
            due_cnt_reg <= '0;
        end else if (ctl.clear) begin
            found_reg   <= 1'b0;
            due_cnt_reg <= '0;
        end else if (ctl.load && is_due) begin
            due_cnt_reg <= due_cnt_reg + CW'(1);
            if (better) begin
                found_reg    <= 1'b1;
                best_reg     <= rd_entry;
                best_idx_reg <= rd_idx;
                best_age_reg <= in_age;
            end
        end
    end

    assign found    = found_reg;
    assign best     = best_reg;
    assign best_idx = best_idx_reg;
    assign due_cnt  = due_cnt_reg;

endmodule

// ===== design/dtq_ctrl.sv =====
// Sequencer of the deadline timer queue: schedule writes, tick scans and removals.
// Drives the entry store and the scan accumulator, and hands results to the output stage.
// Depends on dtq_pkg.
module dtq_ctrl #(
    parameter int CAPACITY = dtq_pkg::DEFAULT_CAPACITY
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_operation,
    input  logic [dtq_pkg::DL_W-1:0]        in_deadline,
    input  logic [dtq_pkg::ID_W-1:0]        in_task_id,
    output logic                            mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0]     mem_wr_addr,
    output dtq_pkg::entry_t                 mem_wr_data,
    output logic [$clog2(CAPACITY)-1:0]     mem_rd_addr,
    input  dtq_pkg::entry_t                 mem_rd_data,
    output dtq_pkg::scan_ctl_t              scan_ctl,
    output logic [$clog2(CAPACITY)-1:0]     scan_idx,
    output logic [dtq_pkg::DL_W-1:0]        now_ticks,
    output logic [dtq_pkg::ORDER_W-1:0]     serial,
    input  logic                            found,
    input  dtq_pkg::entry_t                 best,
    input  logic [$clog2(CAPACITY)-1:0]     best_idx,
    input  logic [$clog2(CAPACITY+1)-1:0]   due_cnt,
    input  logic                            out_free,
    output logic                            push,
    output dtq_pkg::result_t                res
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    dtq_pkg::state_t                   state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [dtq_pkg::DL_W-1:0]          now_reg, now_next;
    logic [dtq_pkg::ORDER_W-1:0]       serial_reg, serial_next;
    logic [CW-1:0]                     issue_reg, issue_next;
    logic                              rd_vld_reg, rd_vld_next;
    logic [IW-1:0]                     rd_idx_reg, rd_idx_next;
    logic [dtq_pkg::EMIT_W-1:0]        emit_reg, emit_next;
    dtq_pkg::result_t                  res_reg, res_next;
    logic [CW-1:0]                     last_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= dtq_pkg::ST_IDLE;
            count_reg  <= '0;
            now_reg    <= '0;
            serial_reg <= '0;
            issue_reg  <= '0;
            rd_vld_reg <= 1'b0;
            emit_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            now_reg    <= now_next;
            serial_reg <= serial_next;
            issue_reg  <= issue_next;
            rd_vld_reg <= rd_vld_next;
            emit_reg   <= emit_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        res_reg    <= res_next;
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        now_next    = now_reg;
        serial_next = serial_reg;
        issue_next  = issue_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        emit_next   = emit_reg;
        res_next    = res_reg;
        last_pos    = count_reg - CW'(1);
        in_ready    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = count_reg[IW-1:0];
        mem_wr_data = '{deadline: in_deadline, task_id: in_task_id, order: serial_reg};
        mem_rd_addr = issue_reg[IW-1:0];
        scan_ctl    = '{clear: 1'b0, load: 1'b0};
        push        = 1'b0;

        case (state_reg)
            dtq_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_operation == dtq_pkg::OP_SCHEDULE) begin
                        res_next = '{kind: dtq_pkg::KIND_ACCEPTED, task_id: in_task_id,
                                     deadline: in_deadline, last: 1'b1};
                        if (count_reg == CW'(CAPACITY)) begin
                            res_next.kind = dtq_pkg::KIND_REJECTED;
                        end else begin
                            mem_wr_en   = 1'b1;
                            count_next  = count_reg + CW'(1);
                            serial_next = serial_reg + dtq_pkg::ORDER_W'(1);
                        end
                        state_next = dtq_pkg::ST_PUSH;
                    end else begin
                        if (now_reg != '1) begin
                            now_next = now_reg + dtq_pkg::DL_W'(1);
                        end
                        scan_ctl.clear = 1'b1;
                        issue_next     = '0;
                        emit_next      = '0;
                        state_next     = dtq_pkg::ST_SCAN;
                    end
                end
            end
            dtq_pkg::ST_SCAN: begin
                scan_ctl.load = rd_vld_reg;
                if (issue_reg < count_reg) begin
                    issue_next  = issue_reg + CW'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_reg[IW-1:0];
                end else if (!rd_vld_reg) begin
                    state_next = dtq_pkg::ST_SCAN_END;
                end
            end
            dtq_pkg::ST_SCAN_END: begin
                if (!found) begin
                    state_next = dtq_pkg::ST_IDLE;
                end else begin
                    res_next = '{kind: dtq_pkg::KIND_EXPIRED, task_id: best.task_id,
                                 deadline: best.deadline,
                                 last: (due_cnt == CW'(1)) ||
                                       (emit_reg == dtq_pkg::EMIT_W'(dtq_pkg::MAX_RESULTS - 1))};
                    if (best_idx == last_pos[IW-1:0]) begin
                        count_next = last_pos;
                        state_next = dtq_pkg::ST_PUSH;
                    end else begin
                        state_next = dtq_pkg::ST_MOVE_RD;
                    end
                end
            end
            dtq_pkg::ST_MOVE_RD: begin
                mem_rd_addr = last_pos[IW-1:0];
                state_next  = dtq_pkg::ST_MOVE_WR;
            end
            dtq_pkg::ST_MOVE_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = best_idx;
                mem_wr_data = mem_rd_data;
                count_next  = last_pos;
                state_next  = dtq_pkg::ST_PUSH;
            end
            dtq_pkg::ST_PUSH: begin
                if (out_free) begin
                    push = 1'b1;
                    if (res_reg.last) begin
                        state_next = dtq_pkg::ST_IDLE;
                    end else begin
                        emit_next      = emit_reg + dtq_pkg::EMIT_W'(1);
                        scan_ctl.clear = 1'b1;
                        issue_next     = '0;
                        state_next     = dtq_pkg::ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase
    end

    assign scan_idx  = rd_idx_reg;
    assign now_ticks = now_reg;
    assign serial    = serial_reg;
    assign res       = res_reg;

endmodule

// ===== design/deadline_timer_queue.sv =====
// Deadline timer queue: up to CAPACITY tasks, each an id with an absolute deadline in ticks.
// A schedule beat gives one result, after any wait on the output. A tick beat advances time
// and then, for each expired task, scans every stored entry through the registered read port
// of the entry store, picks the winner, moves the last entry into the freed slot (not needed
// when the winner is the last entry) and offers the result, earliest deadline first, at most
// sixteen per tick; a tick with nothing due still scans every stored entry. One beat is in
// work at a time, and a finished result waits in the output register.
// Depends on dtq_pkg, dtq_entry_mem, dtq_min_finder and dtq_ctrl.
module deadline_timer_queue #(
    parameter int CAPACITY = dtq_pkg::DEFAULT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // deadline [31:0], task_id [39:32]
    input  logic [0:0]  s_tuser,   // operation [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // expired_id [7:0], expired_deadline [39:8]
    output logic [1:0]  m_tuser,   // kind [1:0]
    output logic        m_tlast
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                        mem_wr_en;
    logic [IW-1:0]               mem_wr_addr;
    dtq_pkg::entry_t             mem_wr_data;
    logic [IW-1:0]               mem_rd_addr;
    dtq_pkg::entry_t             mem_rd_data;
    dtq_pkg::scan_ctl_t          scan_ctl;
    logic [IW-1:0]               scan_idx;
    logic [dtq_pkg::DL_W-1:0]    now_ticks;
    logic [dtq_pkg::ORDER_W-1:0] serial;
    logic                        found;
    dtq_pkg::entry_t             best;
    logic [IW-1:0]               best_idx;
    logic [CW-1:0]               due_cnt;
    logic                        out_free;
    logic                        push;
    dtq_pkg::result_t            res;
    logic                        m_tvalid_reg;
    dtq_pkg::result_t            out_reg;

    dtq_entry_mem #(.DEPTH(CAPACITY)) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    dtq_min_finder #(.CAPACITY(CAPACITY)) u_finder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .rd_entry  (mem_rd_data),
        .rd_idx    (scan_idx),
        .now_ticks (now_ticks),
        .serial    (serial),
        .found     (found),
        .best      (best),
        .best_idx  (best_idx),
        .due_cnt   (due_cnt)
    );

    dtq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_operation (s_tuser[0]),
        .in_deadline  (s_tdata[31:0]),
        .in_task_id   (s_tdata[39:32]),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data),
        .scan_ctl     (scan_ctl),
        .scan_idx     (scan_idx),
        .now_ticks    (now_ticks),
        .serial       (serial),
        .found        (found),
        .best         (best),
        .best_idx     (best_idx),
        .due_cnt      (due_cnt),
        .out_free     (out_free),
        .push         (push),
        .res          (res)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.deadline, out_reg.task_id};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    a_push_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!m_tvalid_reg || m_tready))
        else $error("result pushed while the output register was occupied");

    a_one_beat_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a beat was still in work");

    a_schedule_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && (res.kind != dtq_pkg::KIND_EXPIRED)) |-> res.last)
        else $error("schedule answer without last");

    a_run_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input accepted before the expiry run was complete");

endmodule

// ===== test/deadline_timer_queue_chk.sv =====
// Checker for the deadline timer queue: watches both stream channels, predicts every result beat
// from the accepted input beats and compares it with what the block delivers.
// Depends on dtq_pkg for field widths and result kinds.
module deadline_timer_queue_chk #(
    parameter int CAPACITY = dtq_pkg::DEFAULT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // deadline [31:0], task_id [39:32]
    input  logic [0:0]  s_tuser,   // operation [0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // expired_id [7:0], expired_deadline [39:8]
    input  logic [1:0]  m_tuser,   // kind [1:0]
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import dtq_pkg::*;

    localparam int PRINT_LIMIT = 100;

    logic [DL_W-1:0]    held_deadline [CAPACITY];
    logic [ID_W-1:0]    held_task     [CAPACITY];
    logic [ORDER_W-1:0] held_serial   [CAPACITY];
    int                 held_count;
    logic [DL_W-1:0]    clock_now;
    logic [ORDER_W-1:0] next_serial;
    result_t            due_results [$];

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t: deadline timer queue mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    task automatic queue_result(input result_t r);
        due_results.insert(due_results.size(), r);
    endtask

    task automatic predict_schedule(input logic [DL_W-1:0] dl, input logic [ID_W-1:0] id);
        result_t res;
        res.task_id  = id;
        res.deadline = dl;
        res.last     = 1'b1;
        if (held_count >= CAPACITY) begin
            res.kind = KIND_REJECTED;
        end else begin
            res.kind                  = KIND_ACCEPTED;
            held_deadline[held_count] = dl;
            held_task[held_count]     = id;
            held_serial[held_count]   = next_serial;
            next_serial++;
            held_count++;
        end
        queue_result(res);
    endtask

    // Earliest deadline goes first; equal deadlines go by age against the next serial, so the
    // order survives the serial wrapping round. The freed slot takes the last entry.
    task automatic predict_tick();
        result_t            held_res;
        logic               have_held;
        int                 best;
        int                 n;
        int                 i;
        logic [ORDER_W-1:0] best_age;
        logic [ORDER_W-1:0] age;
        have_held = 1'b0;
        if (clock_now != '1) begin
            clock_now++;
        end
        for (n = 0; n < MAX_RESULTS; n++) begin
            best     = -1;
            best_age = '0;
            for (i = 0; i < held_count; i++) begin
                age = held_serial[i] - next_serial;
                if (held_deadline[i] <= clock_now &&
                    (best < 0 || held_deadline[i] < held_deadline[best] ||
                     (held_deadline[i] == held_deadline[best] && age < best_age))) begin
                    best     = i;
                    best_age = age;
                end
            end
            if (best < 0) begin
                break;
            end
            if (have_held) begin
                queue_result(held_res);
            end
            held_res.kind     = KIND_EXPIRED;
            held_res.task_id  = held_task[best];
            held_res.deadline = held_deadline[best];
            held_res.last     = 1'b0;
            have_held         = 1'b1;
            held_count--;
            held_deadline[best] = held_deadline[held_count];
            held_task[best]     = held_task[held_count];
            held_serial[best]   = held_serial[held_count];
        end
        if (have_held) begin
            held_res.last = 1'b1;
            queue_result(held_res);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            held_count     = 0;
            clock_now      = '0;
            next_serial    = '0;
            mismatch_count = 0;
            due_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_SCHEDULE) begin
                    predict_schedule(s_tdata[31:0], s_tdata[39:32]);
                end else begin
                    predict_tick();
                end
            end
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "result beat with nothing expected: kind %0d id %02h deadline %08h",
                        m_tuser, m_tdata[7:0], m_tdata[39:8]));
                end else begin
                    want = due_results.pop_front();
                    if (m_tuser !== want.kind || m_tdata[7:0] !== want.task_id ||
                        m_tdata[39:8] !== want.deadline || m_tlast !== want.last) begin
                        report_mismatch($sformatf(
                            {"got kind %0d id %02h deadline %08h last %0b, ",
                             "wanted kind %0d id %02h deadline %08h last %0b"},
                            m_tuser, m_tdata[7:0], m_tdata[39:8], m_tlast,
                            want.kind, want.task_id, want.deadline, want.last));
                    end
                end
            end
        end
        outstanding <= due_results.size();
    end

endmodule

// ===== test/deadline_timer_queue_tb.sv =====
// Top of the deadline timer queue testbench: clock, reset, input beats and output back-pressure.
// Instantiates the block and deadline_timer_queue_chk, which does all prediction and comparison.
// Depends on dtq_pkg and the design files.
module deadline_timer_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dtq_pkg::*;

    localparam int RANDOM_ITEMS    = 240;
    localparam int CALM_ITEMS      = 40;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 60;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 80;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // deadline [31:0], task_id [39:32]
    logic [0:0]  s_tuser;   // operation [0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // expired_id [7:0], expired_deadline [39:8]
    logic [1:0]  m_tuser;   // kind [1:0]
    logic        m_tlast;

    int              mismatch_count;
    int              outstanding;
    int              idle_cycles = 0;
    int              items_sent  = 0;
    logic [DL_W-1:0] now_mirror  = '0;
    bit              calm        = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    deadline_timer_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    deadline_timer_queue_chk u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    task automatic offer(input logic op, input logic [DL_W-1:0] dl, input logic [ID_W-1:0] id);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {id, dl};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_sent++;
        if (op == OP_TICK && now_mirror != '1) begin
            now_mirror++;
        end
    endtask

    // Deadlines mostly fall due within a few ticks; some are already overdue.
    task automatic schedule_random();
        logic [DL_W-1:0] dl;
        if ($urandom_range(0, 9) == 0) begin
            dl = $urandom_range(0, now_mirror);
        end else begin
            dl = now_mirror + $urandom_range(0, 8);
        end
        offer(OP_SCHEDULE, dl, 8'($urandom_range(0, 255)));
    endtask

    initial begin : stimulus
        int k;
        int random_items;
        int burst;
        int pick;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer(OP_TICK, 32'h0000_0000, 8'h00);
        offer(OP_SCHEDULE, 32'h0000_0000, 8'h00);
        offer(OP_SCHEDULE, 32'hFFFF_FFFF, 8'hFF);
        offer(OP_TICK, 32'hFFFF_FFFF, 8'hFF);
        // Fill the store with interleaved and tied deadlines, then overflow it once.
        for (k = 0; k < 15; k++) begin
            offer(OP_SCHEDULE, now_mirror + 32'(2 - (k * 7) % 3), 8'(k * 37 + 5));
        end
        offer(OP_SCHEDULE, 32'h1234_5678, 8'hA5);
        offer(OP_TICK, 32'h0000_0000, 8'h00);
        offer(OP_TICK, 32'h0000_0000, 8'h00);

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            calm = (random_items >= RANDOM_ITEMS - CALM_ITEMS);
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                burst = $urandom_range(14, 18);
                repeat (burst) schedule_random();
                random_items += burst;
            end else if (pick < 55) begin
                schedule_random();
                random_items++;
            end else begin
                offer(OP_TICK, $urandom(), 8'($urandom()));
                random_items++;
            end
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("deadline_timer_queue_tb passed");
        end else begin
            $display("deadline_timer_queue_tb failed");
        end
        $finish;
    end

    // One long hold-off fills the block and stalls its input; otherwise random bursts.
    initial begin : receiver
        int  hold;
        bit  held_off;
        held_off = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!held_off && items_sent >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                for (hold = 0; hold < HOLD_OFF_CYCLES; hold++) begin
                    @(posedge aclk);
                end
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("deadline_timer_queue_tb failed");
        $finish;
    end

endmodule
